// File: rtl/uer_pkg.sv
package uer_pkg;

    localparam int MAX_DIST_W = 10;
    localparam int TIMEOUT_W  = 16;
    localparam int GAP_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int DIST_W     = 11;
    localparam int TICK_W     = 20;
    localparam int QUOT_W     = 11;
    localparam int REM_W      = 6;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DISTANCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MEDIAN_MODE  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP          = 2'd3;

    localparam logic [MAX_DIST_W-1:0] MAX_DISTANCE_RESET = 10'd400;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET      = 16'd24000;
    localparam logic [GAP_W-1:0]      GAP_RESET          = 20'd60000;

    localparam logic [TICK_W-1:0] LOW_TICKS  = 20'd2;
    localparam logic [TICK_W-1:0] HIGH_TICKS = 20'd10;
    localparam logic [REM_W-1:0]  TICKS_PER_CM = 6'd58;

    typedef logic signed [DIST_W-1:0] dist_t;

endpackage

// File: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger.
// Each input item on the s_ channel is one microsecond tick carrying a start
// request and the sampled echo level. Each input item yields exactly one
// result item on the m_ channel with the trigger pin level, the busy flag, the
// done flag and, when done is set, the distance in cm (-1 on timeout).
// A start while idle sends a 2-tick low, 10-tick high trigger pulse, then the
// echo high width is timed and turned into centimetres by a running quotient
// and remainder, clamped to the configured maximum. In median mode three
// readings separated by a gap are taken and their median is delivered.
// An accepted item's result is registered and shown in the next cycle; one item is taken
// every cycle unless the receiver stalls, set by the single registered tick stage. The
// user writes configuration through the plain write port only while the block idles;
// the block does not enforce this. After reset the block is idle with its registers
// at their default values. When the receiver stalls, the result item is held in the
// output register and s_tready falls until that item is taken; no item is lost.
module ultrasonic_echo_ranger (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // start_req, echo_level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // trigger_out, busy_res, done_res,
                                                       // distance_cm
    input  logic                            cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import uer_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
    localparam logic [2:0] PH_WAIT_RISE = 3'd3;
    localparam logic [2:0] PH_MEASURE   = 3'd4;
    localparam logic [2:0] PH_GAP       = 3'd5;

    localparam logic [1:0] READINGS_N = 2'd3;

    function automatic dist_t mid_of_three(dist_t a, dist_t b, dist_t c);
        dist_t res;
        if ((a >= b && a <= c) || (a <= b && a >= c)) begin
            res = a;
        end else if ((b >= a && b <= c) || (b <= a && b >= c)) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

    logic [MAX_DIST_W-1:0] max_distance_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic                  median_mode_reg;
    logic [GAP_W-1:0]      gap_reg;

    logic [2:0]        phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [1:0]        index_reg, index_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    dist_t             readings_reg [3];
    dist_t             readings_next [3];

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;

    logic              in_accept;
    logic              start_req, echo_level;
    logic [2:0]        ph_cur;
    logic [TICK_W-1:0] tick_cur, tick_inc;
    logic [1:0]        index_cur;
    logic              finished;
    dist_t             value;
    logic [QUOT_W-1:0] cm;
    logic              trigger_out, busy_res, done_res;
    dist_t             distance_cm;

    assign start_req  = s_tdata[0];
    assign echo_level = s_tdata[1];
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign in_accept  = s_tvalid && s_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        index_next    = index_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        readings_next = readings_reg;
        trigger_out   = 1'b0;
        done_res      = 1'b0;
        distance_cm   = '0;
        finished      = 1'b0;
        value         = '0;
        cm            = '0;

        if (phase_reg == PH_IDLE && start_req) begin
            ph_cur    = PH_TRIG_LOW;
            tick_cur  = '0;
            index_cur = '0;
        end else begin
            ph_cur    = phase_reg;
            tick_cur  = tick_reg;
            index_cur = index_reg;
        end
        tick_inc   = tick_cur + 1'b1;
        phase_next = ph_cur;
        tick_next  = tick_cur;
        index_next = index_cur;

        case (ph_cur)
            PH_TRIG_LOW: begin
                tick_next = tick_inc;
                if (tick_inc >= LOW_TICKS) begin
                    phase_next = PH_TRIG_HIGH;
                    tick_next  = '0;
                end
            end
            PH_TRIG_HIGH: begin
                trigger_out = 1'b1;
                tick_next   = tick_inc;
                if (tick_inc >= HIGH_TICKS) begin
                    phase_next = PH_WAIT_RISE;
                    tick_next  = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (echo_level) begin
                    phase_next = PH_MEASURE;
                    tick_next  = {{(TICK_W-1){1'b0}}, 1'b1};
                    quot_next  = '0;
                    rem_next   = {{(REM_W-1){1'b0}}, 1'b1};
                end else begin
                    tick_next = tick_inc;
                    if (tick_inc > {{(TICK_W-TIMEOUT_W){1'b0}}, timeout_reg}) begin
                        finished = 1'b1;
                        value    = -11'sd1;
                    end
                end
            end
            PH_MEASURE: begin
                if (echo_level) begin
                    tick_next = tick_inc;
                    if (rem_reg == TICKS_PER_CM - 1'b1) begin
                        rem_next  = '0;
                        quot_next = quot_reg + 1'b1;
                    end else begin
                        rem_next = rem_reg + 1'b1;
                    end
                    if (tick_inc > {{(TICK_W-TIMEOUT_W){1'b0}}, timeout_reg}) begin
                        finished = 1'b1;
                        value    = -11'sd1;
                    end
                end else begin
                    if (quot_reg > {1'b0, max_distance_reg}) begin
                        cm = {1'b0, max_distance_reg};
                    end else begin
                        cm = quot_reg;
                    end
                    finished = 1'b1;
                    value    = dist_t'(cm);
                end
            end
            PH_GAP: begin
                tick_next = tick_inc;
                if (tick_inc >= gap_reg) begin
                    tick_next = '0;
                    if (index_cur >= READINGS_N) begin
                        done_res    = 1'b1;
                        distance_cm = mid_of_three(readings_reg[0], readings_reg[1],
                                                   readings_reg[2]);
                        index_next  = '0;
                        phase_next  = PH_IDLE;
                    end else begin
                        phase_next = PH_TRIG_LOW;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase

        if (finished) begin
            tick_next = '0;
            if (median_mode_reg) begin
                if (index_cur < READINGS_N) begin
                    readings_next[index_cur] = value;
                end
                index_next = index_cur + 1'b1;
                phase_next = PH_GAP;
            end else begin
                done_res    = 1'b1;
                distance_cm = value;
                index_next  = '0;
                phase_next  = PH_IDLE;
            end
        end

        busy_res = (phase_next != PH_IDLE);

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (in_accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, distance_cm, done_res, busy_res, trigger_out};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_distance_reg <= MAX_DISTANCE_RESET;
            timeout_reg      <= TIMEOUT_RESET;
            median_mode_reg  <= 1'b0;
            gap_reg          <= GAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MAX_DISTANCE: max_distance_reg <= cfg_wdata[MAX_DIST_W-1:0];
                REG_TIMEOUT:      timeout_reg      <= cfg_wdata[TIMEOUT_W-1:0];
                REG_MEDIAN_MODE:  median_mode_reg  <= cfg_wdata[0];
                REG_GAP:          gap_reg          <= cfg_wdata[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            index_reg    <= '0;
            quot_reg     <= '0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                index_reg <= index_next;
                quot_reg  <= quot_next;
                rem_reg   <= rem_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            readings_reg <= readings_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    // The running quotient and remainder always describe the echo width so far.
    property p_quot_tracks_width;
        @(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_MEASURE |->
            ({6'd0, quot_reg} * {11'd0, TICKS_PER_CM}) + {11'd0, rem_reg}
                == tick_reg[16:0];
    endproperty
    a_quot_tracks_width: assert property (p_quot_tracks_width)
        else $error("echo width quotient out of step with tick count");

    property p_done_not_busy;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[2] |-> !m_tdata_reg[1];
    endproperty
    a_done_not_busy: assert property (p_done_not_busy)
        else $error("result delivered while still busy");

    property p_trigger_busy;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[0] |-> m_tdata_reg[1];
    endproperty
    a_trigger_busy: assert property (p_trigger_busy)
        else $error("trigger driven while idle");

    property p_stall_holds_result;
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |=> m_tvalid_reg && $stable(m_tdata_reg);
    endproperty
    a_stall_holds_result: assert property (p_stall_holds_result)
        else $error("stalled result item changed or lost");

    property p_index_range;
        @(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_GAP |-> index_reg < READINGS_N;
    endproperty
    a_index_range: assert property (p_index_range)
        else $error("reading index left at three outside the gap");

endmodule

// File: dv/ultrasonic_echo_ranger_checker.sv
module ultrasonic_echo_ranger_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // start_req, echo_level
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,   // trigger_out, busy_res, done_res,
                                                      // distance_cm
    input  logic                           cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             done_count,
    output logic                           model_busy
);
    import uer_pkg::*;

    localparam int unsigned PULSE_LOW_TICKS   = 2;
    localparam int unsigned PULSE_HIGH_TICKS  = 10;
    localparam int unsigned ECHO_TICKS_PER_CM = 58;

    typedef enum logic [2:0] {
        RANGE_IDLE,
        PULSE_LOW,
        PULSE_HIGH,
        AWAIT_ECHO,
        TIME_ECHO,
        SETTLE_GAP
    } ranger_phase_t;

    typedef struct packed {
        logic  trigger;
        logic  busy;
        logic  done;
        dist_t distance;
    } ranger_result_t;

    logic [MAX_DIST_W-1:0] max_dist_cm  = MAX_DISTANCE_RESET;
    logic [TIMEOUT_W-1:0]  echo_timeout = TIMEOUT_RESET;
    logic                  median_on    = 1'b0;
    logic [GAP_W-1:0]      gap_len      = GAP_RESET;

    ranger_phase_t         phase        = RANGE_IDLE;
    logic [TICK_W-1:0]     tick_cnt     = '0;
    dist_t                 reading_buf [3];
    logic [1:0]            reading_cnt  = '0;

    ranger_result_t        expected_results [$];
    int                    errors       = 0;
    int                    reports      = 0;

    function automatic dist_t median3(dist_t a, dist_t b, dist_t c);
        dist_t lo;
        dist_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) return lo;
        if (c >= hi) return hi;
        return c;
    endfunction

    // Advances the ranger by one tick and returns the result item it gives.
    function automatic ranger_result_t ranger_tick(input logic start, input logic echo);
        ranger_result_t    r;
        logic              finished;
        dist_t             reading;
        logic [TICK_W-1:0] cm;
        r        = '0;
        finished = 1'b0;
        reading  = '0;

        if (phase == RANGE_IDLE && start) begin
            phase       = PULSE_LOW;
            tick_cnt    = '0;
            reading_cnt = '0;
        end

        case (phase)
            RANGE_IDLE: begin
            end
            PULSE_LOW: begin
                tick_cnt++;
                if (tick_cnt >= PULSE_LOW_TICKS) begin
                    phase    = PULSE_HIGH;
                    tick_cnt = '0;
                end
            end
            PULSE_HIGH: begin
                r.trigger = 1'b1;
                tick_cnt++;
                if (tick_cnt >= PULSE_HIGH_TICKS) begin
                    phase    = AWAIT_ECHO;
                    tick_cnt = '0;
                end
            end
            AWAIT_ECHO: begin
                if (echo) begin
                    phase    = TIME_ECHO;
                    tick_cnt = TICK_W'(1);
                end else begin
                    tick_cnt++;
                    if (tick_cnt > echo_timeout) begin
                        finished = 1'b1;
                        reading  = -11'sd1;
                    end
                end
            end
            TIME_ECHO: begin
                if (echo) begin
                    tick_cnt++;
                    if (tick_cnt > echo_timeout) begin
                        finished = 1'b1;
                        reading  = -11'sd1;
                    end
                end else begin
                    cm = TICK_W'(tick_cnt / ECHO_TICKS_PER_CM);
                    if (cm > max_dist_cm) cm = {{(TICK_W-MAX_DIST_W){1'b0}}, max_dist_cm};
                    finished = 1'b1;
                    reading  = $signed({1'b0, cm[MAX_DIST_W-1:0]});
                end
            end
            SETTLE_GAP: begin
                tick_cnt++;
                if (tick_cnt >= gap_len) begin
                    tick_cnt = '0;
                    if (reading_cnt >= 3) begin
                        r.done      = 1'b1;
                        r.distance  = median3(reading_buf[0], reading_buf[1], reading_buf[2]);
                        reading_cnt = '0;
                        phase       = RANGE_IDLE;
                    end else begin
                        phase = PULSE_LOW;
                    end
                end
            end
            default: begin
                phase    = RANGE_IDLE;
                tick_cnt = '0;
            end
        endcase

        if (finished) begin
            tick_cnt = '0;
            if (median_on) begin
                if (reading_cnt < 3) reading_buf[reading_cnt] = reading;
                reading_cnt++;
                phase = SETTLE_GAP;
            end else begin
                r.done      = 1'b1;
                r.distance  = reading;
                reading_cnt = '0;
                phase       = RANGE_IDLE;
            end
        end

        r.busy = (phase != RANGE_IDLE);
        return r;
    endfunction

    always @(posedge aclk) begin
        ranger_result_t want;
        ranger_result_t got;
        if (!aresetn) begin
            max_dist_cm  = MAX_DISTANCE_RESET;
            echo_timeout = TIMEOUT_RESET;
            median_on    = 1'b0;
            gap_len      = GAP_RESET;
            phase        = RANGE_IDLE;
            tick_cnt     = '0;
            reading_cnt  = '0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MAX_DISTANCE: max_dist_cm  = cfg_wdata[MAX_DIST_W-1:0];
                    REG_TIMEOUT:      echo_timeout = cfg_wdata[TIMEOUT_W-1:0];
                    REG_MEDIAN_MODE:  median_on    = cfg_wdata[0];
                    REG_GAP:          gap_len      = cfg_wdata[GAP_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.trigger  = m_tdata[0];
                got.busy     = m_tdata[1];
                got.done     = m_tdata[2];
                got.distance = m_tdata[3 +: DIST_W];
                if (expected_results.size() == 0) begin
                    errors++;
                    $error("result item arrived with no prediction waiting");
                end else begin
                    want = expected_results.pop_front();
                    if (got.trigger !== want.trigger) begin
                        errors++;
                        $error("trigger_out expected %0d got %0d", want.trigger, got.trigger);
                    end
                    if (got.busy !== want.busy) begin
                        errors++;
                        $error("busy_res expected %0d got %0d", want.busy, got.busy);
                    end
                    if (got.done !== want.done) begin
                        errors++;
                        $error("done_res expected %0d got %0d", want.done, got.done);
                    end
                    if (got.distance !== want.distance) begin
                        errors++;
                        $error("distance_cm expected %0d got %0d", want.distance, got.distance);
                    end
                    if (want.done) reports++;
                end
            end

            if (s_tvalid && s_tready) begin
                expected_results.push_back(ranger_tick(s_tdata[0], s_tdata[1]));
            end
        end

        fail_count <= errors;
        pending    <= expected_results.size();
        done_count <= reports;
        model_busy <= (phase != RANGE_IDLE);
    end

endmodule

// File: dv/testbench.sv
module testbench;
    import uer_pkg::*;

    localparam int RECEIVER_HOLD_CYCLES = 200;
    localparam int RANDOM_TICK_TARGET   = 150;
    localparam int DRAIN_CYCLES         = 10;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int                    fail_count;
    int                    pending;
    int                    done_count;
    logic                  model_busy;

    bit                    idle_on       = 1'b1;
    bit                    rx_hold       = 1'b0;
    int                    ticks_sent    = 0;
    int                    settings_used = 0;

    logic [MAX_DIST_W-1:0] cur_max     = MAX_DISTANCE_RESET;
    logic [TIMEOUT_W-1:0]  cur_timeout = TIMEOUT_RESET;
    logic                  cur_median  = 1'b0;
    logic [GAP_W-1:0]      cur_gap     = GAP_RESET;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    ultrasonic_echo_ranger uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    ultrasonic_echo_ranger_checker ranger_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .done_count (done_count),
        .model_busy (model_busy)
    );

    initial begin
        @(posedge aclk);
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (RECEIVER_HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic send_tick(input logic start, input logic echo);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, echo, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
    endtask

    // Stops offering items, then feeds quiet ticks until the ranger is idle
    // and every predicted item has come back.
    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || model_busy) begin
            if (pending == 0) begin
                send_tick(1'b0, 1'b0);
                s_tvalid <= 1'b0;
            end
            @(posedge aclk);
        end
    endtask

    task automatic set_config(input logic [MAX_DIST_W-1:0] max_cm,
                              input logic [TIMEOUT_W-1:0]  timeout,
                              input logic                  median,
                              input logic [GAP_W-1:0]      gap);
        cur_max     = max_cm;
        cur_timeout = timeout;
        cur_median  = median;
        cur_gap     = gap;
        settings_used++;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_MAX_DISTANCE;
        cfg_wdata <= {{(CFG_DATA_W-MAX_DIST_W){1'b0}}, max_cm};
        @(posedge aclk);
        cfg_addr  <= REG_TIMEOUT;
        cfg_wdata <= {{(CFG_DATA_W-TIMEOUT_W){1'b0}}, timeout};
        @(posedge aclk);
        cfg_addr  <= REG_MEDIAN_MODE;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, median};
        @(posedge aclk);
        cfg_addr  <= REG_GAP;
        cfg_wdata <= gap;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One trigger pulse and echo. A wait or width past the timeout is cut to
    // the tick on which the timeout fires, so the next reading stays aligned.
    task automatic echo_reading(input bit with_start, input int wait_ticks, input int width,
                                input bit noisy, input bit hold_start);
        send_tick(with_start, noisy ? 1'($urandom_range(0, 1)) : 1'b0);
        repeat (11) send_tick(hold_start, noisy ? 1'($urandom_range(0, 1)) : 1'b0);
        if (wait_ticks > int'(cur_timeout)) begin
            repeat (int'(cur_timeout) + 1) send_tick(hold_start, 1'b0);
        end else begin
            repeat (wait_ticks) send_tick(hold_start, 1'b0);
            if (width > int'(cur_timeout)) begin
                repeat (int'(cur_timeout) + 1) send_tick(hold_start, 1'b1);
            end else begin
                repeat (width) send_tick(hold_start, 1'b1);
                send_tick(hold_start, 1'b0);
            end
        end
    endtask

    task automatic run_sequence(input int wait0, input int width0,
                                input int wait1, input int width1,
                                input int wait2, input int width2,
                                input bit noisy, input bit hold_start);
        int waits  [3];
        int widths [3];
        waits[0]  = wait0;
        waits[1]  = wait1;
        waits[2]  = wait2;
        widths[0] = width0;
        widths[1] = width1;
        widths[2] = width2;
        for (int k = 0; k < (cur_median ? 3 : 1); k++) begin
            echo_reading(k == 0, waits[k], widths[k], noisy, hold_start);
            if (cur_median) begin
                repeat ((cur_gap == 0) ? 1 : int'(cur_gap))
                    send_tick(hold_start, noisy ? 1'($urandom_range(0, 1)) : 1'b0);
            end
        end
    endtask

    function automatic int pick_wait();
        if ($urandom_range(0, 9) == 0) return int'(cur_timeout) + 1;
        return $urandom_range(0, (cur_timeout < 15) ? int'(cur_timeout) : 15);
    endfunction

    function automatic int pick_width();
        if ($urandom_range(0, 9) == 0) return int'(cur_timeout) + 1;
        return $urandom_range(1, (cur_timeout < 90) ? int'(cur_timeout) : 90);
    endfunction

    initial begin
        int rand_start;
        int phase_no;
        logic [MAX_DIST_W-1:0] pick_max;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: echo already high as the pulse ends, widths either
        // side of one centimetre, and a start held high while busy.
        echo_reading(1'b1, 0, 58, 1'b1, 1'b0);
        echo_reading(1'b1, 1, 57, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1);

        // Shortest timeout: echo never rises, echo stays high, and an echo that fits in time.
        go_idle();
        set_config(10'd0, 16'd1, 1'b0, 20'd0);
        echo_reading(1'b1, 2, 1, 1'b0, 1'b0);
        echo_reading(1'b1, 0, 3, 1'b0, 1'b0);
        echo_reading(1'b1, 1, 1, 1'b0, 1'b0);

        // A one-centimetre echo clamped to a zero maximum.
        go_idle();
        set_config(10'd0, 16'd80, 1'b0, 20'd0);
        echo_reading(1'b1, 0, 58, 1'b0, 1'b0);

        // Median of three with a timeout taking part, zero gap.
        go_idle();
        set_config(10'd1023, 16'd60, 1'b1, 20'd0);
        run_sequence(0, 58, 61, 1, 0, 4, 1'b0, 1'b0);

        go_idle();
        set_config(10'd5, 16'd20, 1'b1, 20'd3);
        run_sequence(0, 21, 2, 5, 21, 1, 1'b0, 1'b0);

        rand_start = ticks_sent;
        phase_no   = 0;
        while ((ticks_sent - rand_start) < RANDOM_TICK_TARGET) begin
            go_idle();
            case ($urandom_range(0, 3))
                0:       pick_max = 10'd0;
                1:       pick_max = 10'd1023;
                2:       pick_max = 10'($urandom_range(0, 4));
                default: pick_max = 10'($urandom_range(0, 1023));
            endcase
            set_config(pick_max,
                       ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(2, 90)),
                       1'($urandom_range(0, 1)),
                       ($urandom_range(0, 3) == 0) ? 20'd0 : 20'($urandom_range(1, 12)));
            if (phase_no == 0) rx_hold = 1'b1;
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(5, 30))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    run_sequence(pick_wait(), pick_width(), pick_wait(), pick_width(),
                                 pick_wait(), pick_width(),
                                 $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
                end
                repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
            end
            phase_no++;
        end

        // Closing stretch with both sides streaming at full rate.
        go_idle();
        idle_on = 1'b0;
        set_config(10'($urandom_range(0, 1023)), 16'($urandom_range(20, 60)), 1'b1,
                   20'($urandom_range(0, 20)));
        run_sequence(pick_wait(), pick_width(), pick_wait(), pick_width(),
                     pick_wait(), pick_width(), 1'b0, 1'b0);

        go_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d echo ticks under %0d register settings, single and median.",
                 ticks_sent, settings_used);
        $display("Checked %0d distance reports, timeouts and clamps among them.", done_count);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
